FILE: rtl/job_resource_ledger_top_assert.svh
// Assertion macros for the job resource ledger.
`ifndef JOB_RESOURCE_LEDGER_TOP_ASSERT_SVH
`define JOB_RESOURCE_LEDGER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define JRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define JRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/jrl_pkg.sv
// Shared types and constants for the job resource ledger.
`timescale 1ns / 1ps
`default_nettype none
package jrl_pkg;
  localparam logic [1:0] ACT_ASSIGN  = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_SOCKDN  = 2'd2;
  localparam logic [1:0] ACT_IGNORE  = 2'd3;
  localparam logic [1:0] RES_CPU     = 2'd0;
  localparam logic [1:0] RES_GPU     = 2'd1;
  localparam logic [1:0] RES_MEM     = 2'd2;
  localparam logic [1:0] RES_UNKNOWN = 2'd3;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADRES   = 2'd3;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned JOB_W  = 16;
  localparam int unsigned SOCK_W = 10;
  // Row: valid, job, owner, cpu, gpu, mem
  localparam int unsigned ROW_W  = 1 + JOB_W + SOCK_W + 3 * CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
endpackage
`default_nettype wire

FILE: rtl/job_resource_ledger_top.sv
// Job resource ledger: job table in RAM, walked by a sequencer.
// Each item runs a full scan of the table, then one read-modify-write step
// before its result word (a socket-down item emits its nonzero totals instead).
// One item at a time: the input is stalled until the item is done, and the
// scan runs over the single RAM read port.
// Reset: valid bits live in the RAM; a clearing pass over every entry runs
// after reset with the input stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "job_resource_ledger_top_assert.svh"
module job_resource_ledger_top
  import jrl_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] job_id_i,
  input  wire logic [9:0]  socket_i,
  input  wire logic [1:0]  resource_i,
  input  wire logic [15:0] amount_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      freed_amount_o,
  output logic [1:0]       res_kind_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  localparam int unsigned AW = $clog2(ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [1:0]        act_q;
  logic [JOB_W-1:0]  job_q;
  logic [SOCK_W-1:0] sock_q;
  logic [1:0]        res_q;
  logic [15:0]       amt_q;
  logic [AW:0]       ridx_q;          // read/clear address counter, one past depth
  logic              rv_q;            // read data valid this cycle
  logic [AW-1:0]     rslot_q;         // slot of read data
  logic              hit_q, free_q;
  logic [AW-1:0]     hit_slot_q, free_slot_q;
  logic [31:0]       tot_q [3];
  logic [1:0]        ek_q;            // next emit kind to consider

  // Table RAM: valid, job, owner, cpu, gpu, mem
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ROW_W-1:0]  wdata, rdata;

  jrl_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_tab (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic              r_v;
  logic [JOB_W-1:0]  r_job;
  logic [SOCK_W-1:0] r_own;
  logic [CNT_W-1:0]  r_cnt [3];
  assign r_v      = rdata[ROW_W-1];
  assign r_job    = rdata[ROW_W-2 -: JOB_W];
  assign r_own    = rdata[3*CNT_W +: SOCK_W];
  assign r_cnt[0] = rdata[2*CNT_W +: CNT_W];
  assign r_cnt[1] = rdata[CNT_W +: CNT_W];
  assign r_cnt[2] = rdata[0 +: CNT_W];

  // Scan matches on the row just read
  logic sweep_hit, job_hit;
  assign sweep_hit = rv_q && r_v && act_q == ACT_SOCKDN && r_own == sock_q;
  assign job_hit   = rv_q && r_v && act_q != ACT_SOCKDN && r_job == job_q;

  logic in_acc, out_acc, scan_done;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign scan_done  = (ridx_q == (AW+1)'(ENTRIES)) && !rv_q;

  // RMW cycle: counter update on the hit/new slot (read data of hit slot)
  logic [1:0]        kind;
  logic              row_v;
  logic [CNT_W-1:0]  cur [3];
  logic [CNT_W-1:0]  cur_sel, new_cnt, freed;
  logic [CNT_W:0]    sum;
  assign kind  = (res_q == RES_UNKNOWN) ? RES_CPU : res_q;
  assign row_v = hit_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k] = row_v ? r_cnt[k] : '0;
    end
    cur_sel = cur[kind];
    sum     = {1'b0, cur_sel} + (CNT_W+1)'(amt_q);
    freed   = ((CNT_W)'(amt_q) > cur_sel) ? cur_sel : CNT_W'(amt_q);
    if (act_q == ACT_ASSIGN) begin
      new_cnt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    end else begin
      new_cnt = cur_sel - freed;
    end
  end

  logic [CNT_W-1:0] upd [3];
  logic             all_zero;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      upd[k] = (2'(k) == kind && res_q != RES_UNKNOWN) ? new_cnt : cur[k];
    end
    all_zero = (upd[0] == '0) && (upd[1] == '0) && (upd[2] == '0);
  end

  logic [AW-1:0]     tgt;
  logic              row_keep;
  logic [SOCK_W-1:0] own_new;
  assign tgt      = hit_q ? hit_slot_q : free_slot_q;
  // release frees the slot once every counter is zero
  assign row_keep = (act_q == ACT_ASSIGN) ? 1'b1 : !all_zero;
  // owner is recorded only when the job is created
  assign own_new  = hit_q ? r_own : sock_q;

  // RAM port control
  always_comb begin
    raddr = ridx_q[AW-1:0];
    if (state_q == S_SCAN && ridx_q == (AW+1)'(ENTRIES)) begin
      raddr = tgt;
    end
    we    = 1'b0;
    waddr = tgt;
    wdata = {row_keep, job_q, own_new, upd[0], upd[1], upd[2]};
    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = ridx_q[AW-1:0];
        wdata = '0;
      end
      S_SCAN: begin
        if (sweep_hit) begin
          we    = 1'b1;
          waddr = rslot_q;
          wdata = {1'b0, rdata[ROW_W-2:0]};
        end
      end
      S_RMW: begin
        if (act_q == ACT_ASSIGN && (hit_q || free_q)) begin
          we = 1'b1;
        end
        if (act_q == ACT_RELEASE && hit_q && res_q != RES_UNKNOWN) begin
          we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next emit kind: lowest nonzero total at or above ek_q
  logic [1:0] nxt_k;
  logic       more;
  always_comb begin
    nxt_k = ek_q;
    more  = 1'b0;
    for (int k = 2; k >= 0; k--) begin
      if (2'(k) >= ek_q && tot_q[k] != '0) begin
        nxt_k = 2'(k);
        more  = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR: if (ridx_q == (AW+1)'(ENTRIES - 1)) begin
        state_d = S_IDLE;
      end
      S_IDLE: if (in_acc) begin
        state_d = (action_i == ACT_IGNORE) ? S_IDLE : S_SCAN;
      end
      S_SCAN: if (scan_done) begin
        state_d = (act_q == ACT_SOCKDN) ? S_EMIT : S_RMW;
      end
      S_RMW:  state_d = S_WAIT;
      S_EMIT: state_d = more ? S_WAIT : S_IDLE;
      S_WAIT: if (out_acc && (act_q != ACT_SOCKDN || !more)) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output word registers
  logic [31:0] fa_q;
  logic [1:0]  rk_q, st_q;
  logic        last_q, ov_q;
  assign out_valid_o    = ov_q;
  assign freed_amount_o = fa_q;
  assign res_kind_o     = rk_q;
  assign status_o       = st_q;
  assign last_o         = last_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ridx_q  <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      ek_q    <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      case (state_q)
        S_CLR: begin
          ridx_q <= ridx_q + (AW+1)'(1);
        end
        S_IDLE: begin
          ridx_q <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          ek_q   <= '0;
        end
        S_SCAN: begin
          if (ridx_q != (AW+1)'(ENTRIES)) begin
            ridx_q <= ridx_q + (AW+1)'(1);
            rv_q   <= 1'b1;
          end
          if (job_hit) begin
            hit_q <= 1'b1;
          end
          if (rv_q && !r_v && !free_q) begin
            free_q <= 1'b1;
          end
        end
        S_RMW: begin
          ov_q <= 1'b1;
        end
        S_EMIT: begin
          ek_q <= nxt_k + 2'd1;
          ov_q <= more;
        end
        S_WAIT: if (out_acc) begin
          ov_q <= 1'b0;
          if (act_q == ACT_SOCKDN) begin
            ek_q <= nxt_k + 2'd1;
            ov_q <= more;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  logic [1:0] sd_k;
  logic       sd_last;
  always_comb begin
    sd_k    = nxt_k;
    sd_last = 1'b1;
    for (int k = 2; k >= 0; k--) begin
      if (2'(k) > nxt_k && tot_q[k] != '0) begin
        sd_last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q <= ridx_q[AW-1:0];
    if (in_acc) begin
      act_q  <= action_i;
      job_q  <= job_id_i;
      sock_q <= socket_i;
      res_q  <= resource_i;
      amt_q  <= amount_i;
      for (int k = 0; k < 3; k++) begin
        tot_q[k] <= '0;
      end
    end
    if (state_q == S_IDLE) begin
      free_slot_q <= '0;
      hit_slot_q  <= '0;
    end
    if (state_q == S_SCAN) begin
      if (sweep_hit) begin
        for (int k = 0; k < 3; k++) begin
          tot_q[k] <= tot_q[k] + 32'(r_cnt[k]);
        end
      end
      if (job_hit) begin
        hit_slot_q <= rslot_q;
      end
      if (rv_q && !r_v && !free_q) begin
        free_slot_q <= rslot_q;
      end
    end
    if (state_q == S_RMW) begin
      fa_q   <= '0;
      rk_q   <= kind;
      last_q <= 1'b1;
      if (act_q == ACT_ASSIGN) begin
        if (!hit_q && !free_q) begin
          st_q <= ST_FULL;
        end else if (res_q == RES_UNKNOWN) begin
          st_q <= ST_BADRES;
        end else begin
          st_q <= ST_OK;
        end
      end else if (!hit_q) begin
        st_q <= ST_NOTFOUND;
      end else if (res_q == RES_UNKNOWN) begin
        st_q <= ST_BADRES;
      end else begin
        st_q <= ST_OK;
        fa_q <= 32'(freed);
      end
    end
    if (more && ((state_q == S_EMIT) ||
                 (state_q == S_WAIT && out_acc && act_q == ACT_SOCKDN))) begin
      fa_q   <= tot_q[sd_k];
      rk_q   <= sd_k;
      st_q   <= ST_OK;
      last_q <= sd_last;
    end
  end

  `JRL_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `JRL_ASSERT_NXT(a_rmw_out, clk_i, rst_ni, state_q == S_RMW, out_valid_o)
  `JRL_ASSERT_IMP(a_idle_quiet, clk_i, rst_ni, state_q == S_IDLE, !out_valid_o)
endmodule
`default_nettype wire

FILE: rtl/jrl_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module jrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
